[sv/rsbk_pkg.sv]
// rsbk_pkg: constants, record and control types for the record sort block.
// No dependencies; used by rsbk_cell, record_sort_by_key and the testbench.
`default_nettype none

package rsbk_pkg;

    localparam int DEPTH    = 64;
    localparam int KEY_BITS = 32;
    // keys are ordered on at most 32 bits
    localparam int CMP_BITS = (KEY_BITS > 32) ? 32 : KEY_BITS;
    localparam int FILL_W   = $clog2(DEPTH + 1);

    typedef struct packed {
        logic signed [CMP_BITS-1:0] key;
        logic [31:0]                label;
        logic [31:0]                weight;
    } t_rec;

    typedef struct packed {
        logic ins;    // insert the new word into the chain
        logic shift;  // move every cell one place towards cell 0
    } t_cell_ctl;

    typedef enum logic [0:0] {
        ST_FILL  = 1'b0,
        ST_DRAIN = 1'b1
    } t_state;

endpackage

`default_nettype wire

[sv/rsbk_in_if.sv]
// rsbk_in_if: valid/ready channel carrying one unsorted record.
// Depends on nothing.
`default_nettype none

interface rsbk_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sort_key;
    logic [31:0]        label_word;
    logic [31:0]        weight_word;
    logic               final_record;

    modport source (output valid, sort_key, label_word, weight_word, final_record,
                    input ready);
    modport sink   (input valid, sort_key, label_word, weight_word, final_record,
                    output ready);
endinterface

`default_nettype wire

[sv/rsbk_out_if.sv]
// rsbk_out_if: valid/ready channel carrying one sorted record.
// Depends on nothing.
`default_nettype none

interface rsbk_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sorted_key;
    logic [31:0]        sorted_label;
    logic [31:0]        sorted_weight;
    logic               end_of_run;
    logic               overflow;

    modport source (output valid, sorted_key, sorted_label, sorted_weight, end_of_run,
                    overflow, input ready);
    modport sink   (input valid, sorted_key, sorted_label, sorted_weight, end_of_run,
                    overflow, output ready);
endinterface

`default_nettype wire

[sv/rsbk_cell.sv]
// rsbk_cell: one place of the insertion chain, holding a single record.
// Depends on rsbk_pkg.
`default_nettype none

module rsbk_cell (
    input  wire logic               i_clk,
    input  wire rsbk_pkg::t_cell_ctl i_ctl,
    input  wire logic               i_occ,
    input  wire logic               i_prev_gt,
    input  wire rsbk_pkg::t_rec     i_prev,
    input  wire rsbk_pkg::t_rec     i_next,
    input  wire rsbk_pkg::t_rec     i_new,
    output rsbk_pkg::t_rec          o_rec,
    output logic                    o_gt
);

    rsbk_pkg::t_rec r_rec;
    rsbk_pkg::t_rec n_rec;

    // strictly greater only, so equal keys stay in arrival order
    assign o_gt  = i_occ && ($signed(r_rec.key) > $signed(i_new.key));
    assign o_rec = r_rec;

    always_comb begin
        n_rec = r_rec;
        if (i_ctl.shift) begin
            n_rec = i_next;
        end else if (i_ctl.ins) begin
            if (i_prev_gt) begin
                n_rec = i_prev;
            end else if (o_gt || !i_occ) begin
                n_rec = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

`default_nettype wire

[sv/record_sort_by_key.sv]
// record_sort_by_key: stable sort of a record set in a chain of insertion cells.
// Depends on rsbk_pkg, rsbk_in_if, rsbk_out_if and rsbk_cell.
//
//  port    | dir | words                                  | handshake
//  i_in    | in  | sort_key, label_word, weight_word, fin | valid/ready
//  o_out   | out | sorted_key/label/weight, eor, overflow | valid/ready
//
// A record is inserted as it is accepted; every cell compares against it in parallel.
// After the final record the set leaves from cell 0, one word a cycle while o_out
// is ready, n words for n stored records (at most DEPTH); i_in.ready is low meanwhile.
// Reset (synchronous, active low) empties the chain via the fill count.
// A stalled output holds the word in cell 0 unchanged.
`default_nettype none

module record_sort_by_key (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rsbk_in_if.sink   i_in,
    rsbk_out_if.source o_out
);

    localparam int D = rsbk_pkg::DEPTH;

    rsbk_pkg::t_state               r_state;
    rsbk_pkg::t_state               n_state;
    logic [rsbk_pkg::FILL_W-1:0]    r_fill;
    logic [rsbk_pkg::FILL_W-1:0]    n_fill;
    logic                           r_dropped;
    logic                           n_dropped;
    logic                           in_acc;
    logic                           out_acc;
    logic                           full;
    rsbk_pkg::t_cell_ctl            ctl;
    rsbk_pkg::t_rec                 new_rec;
    rsbk_pkg::t_rec                 w_rec [D];
    logic                           w_gt  [D];

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;
    assign full    = (r_fill == rsbk_pkg::FILL_W'(D));

    assign new_rec.key    = i_in.sort_key[rsbk_pkg::CMP_BITS-1:0];
    assign new_rec.label  = i_in.label_word;
    assign new_rec.weight = i_in.weight_word;

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_dropped = r_dropped;
        ctl.ins   = 1'b0;
        ctl.shift = 1'b0;
        case (r_state)
            rsbk_pkg::ST_FILL: begin
                if (in_acc) begin
                    if (full) begin
                        n_dropped = 1'b1;
                    end else begin
                        ctl.ins = 1'b1;
                        n_fill  = r_fill + 1'b1;
                    end
                    if (i_in.final_record) begin
                        n_state = rsbk_pkg::ST_DRAIN;
                    end
                end
            end
            rsbk_pkg::ST_DRAIN: begin
                if (out_acc) begin
                    ctl.shift = 1'b1;
                    n_fill    = r_fill - 1'b1;
                    if (r_fill == rsbk_pkg::FILL_W'(1)) begin
                        n_state   = rsbk_pkg::ST_FILL;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: begin
                n_state = rsbk_pkg::ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rsbk_pkg::ST_FILL;
            r_fill    <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_dropped <= n_dropped;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < D; gi++) begin : g_cell
            rsbk_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (ctl),
                .i_occ     (r_fill > rsbk_pkg::FILL_W'(gi)),
                .i_prev_gt ((gi == 0) ? 1'b0 : w_gt[(gi == 0) ? 0 : gi - 1]),
                .i_prev    (w_rec[(gi == 0) ? 0 : gi - 1]),
                .i_next    (w_rec[(gi == D - 1) ? gi : gi + 1]),
                .i_new     (new_rec),
                .o_rec     (w_rec[gi]),
                .o_gt      (w_gt[gi])
            );
        end
    endgenerate

    assign i_in.ready          = (r_state == rsbk_pkg::ST_FILL);
    assign o_out.valid         = (r_state == rsbk_pkg::ST_DRAIN);
    assign o_out.sorted_key    = 32'(w_rec[0].key);
    assign o_out.sorted_label  = w_rec[0].label;
    assign o_out.sorted_weight = w_rec[0].weight;
    assign o_out.end_of_run    = (r_fill == rsbk_pkg::FILL_W'(1));
    assign o_out.overflow      = r_dropped;

endmodule

`default_nettype wire

[sv/rsbk_check.sv]
// rsbk_check: port-level checks on record_sort_by_key, bound to the top level.
// Depends on record_sort_by_key and its channel interfaces.
`default_nettype none

module rsbk_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_in_final,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_out_key,
    input wire logic        i_out_eor,
    input wire logic        i_out_ovf
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_key)))
        else $error("output word changed while stalled");

    // input is closed while a run is being emitted
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input open during output run");

    // final record starts the run on the next cycle
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_final) |=> i_out_valid)
        else $error("run did not start after final record");

    // taking the last word ends the run
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_eor) |=> !i_out_valid)
        else $error("output continued after end of run");

    // drop flag is constant across one run
    a_ovf_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && $past(i_out_valid)) |-> (i_out_ovf == $past(i_out_ovf)))
        else $error("overflow changed within a run");

endmodule

bind record_sort_by_key rsbk_check u_rsbk_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_final  (i_in.final_record),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_key   (o_out.sorted_key),
    .i_out_eor   (o_out.end_of_run),
    .i_out_ovf   (o_out.overflow)
);

`default_nettype wire

[tb/record_sort_by_key_check.sv]
// record_sort_by_key_check: watches both record channels, predicts every sorted word and compares.
// Depends on rsbk_pkg, rsbk_in_if and rsbk_out_if.
module record_sort_by_key_check (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rsbk_in_if        i_rec,
    rsbk_out_if       i_sorted,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_words_seen,
    output int        o_overflow_runs
);

    localparam int PRINT_CAP = 40;

    typedef struct {
        logic signed [31:0] key;
        logic [31:0]        label;
        logic [31:0]        weight;
    } t_entry;

    typedef struct {
        t_entry ent;
        logic   eor;
        logic   ovf;
    } t_sorted_word;

    t_entry       held_set[$];    // current set, kept in ascending key order
    t_sorted_word sorted_due[$];  // words still owed by the block, oldest first
    logic         set_dropped;

    // keys are ordered on CMP_BITS bits only, sign-extended back to 32
    function automatic logic signed [31:0] trim_key(input logic [31:0] raw);
        logic signed [rsbk_pkg::CMP_BITS-1:0] narrow;
        narrow = raw[rsbk_pkg::CMP_BITS-1:0];
        return 32'(narrow);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_fail_count < PRINT_CAP)
            $display("MISMATCH at word %0d: %s got %h, expected %h",
                     o_words_seen, what, got, want);
        o_fail_count++;
    endtask

    task automatic take_record(input t_entry e, input logic fin);
        int           slot;
        t_sorted_word w;
        if (held_set.size() < rsbk_pkg::DEPTH) begin
            // goes behind every key less than or equal, so ties keep arrival order
            slot = held_set.size();
            while (slot > 0 && held_set[slot-1].key > e.key)
                slot--;
            held_set.insert(slot, e);
        end else begin
            set_dropped = 1'b1;
        end
        if (fin) begin
            foreach (held_set[j]) begin
                w.ent = held_set[j];
                w.eor = (j == held_set.size() - 1);
                w.ovf = set_dropped;
                sorted_due.push_back(w);
            end
            if (set_dropped)
                o_overflow_runs++;
            held_set.delete();
            set_dropped = 1'b0;
        end
    endtask

    task automatic check_word();
        t_sorted_word want;
        if (sorted_due.size() == 0) begin
            report_mismatch("word with nothing due, key", i_sorted.sorted_key, '0);
        end else begin
            want = sorted_due.pop_front();
            if (i_sorted.sorted_key !== want.ent.key)
                report_mismatch("sorted_key", i_sorted.sorted_key, want.ent.key);
            if (i_sorted.sorted_label !== want.ent.label)
                report_mismatch("sorted_label", i_sorted.sorted_label, want.ent.label);
            if (i_sorted.sorted_weight !== want.ent.weight)
                report_mismatch("sorted_weight", i_sorted.sorted_weight, want.ent.weight);
            if (i_sorted.end_of_run !== want.eor)
                report_mismatch("end_of_run", 32'(i_sorted.end_of_run), 32'(want.eor));
            if (i_sorted.overflow !== want.ovf)
                report_mismatch("overflow", 32'(i_sorted.overflow), 32'(want.ovf));
        end
        o_words_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_set.delete();
            sorted_due.delete();
            set_dropped     = 1'b0;
            o_fail_count    = 0;
            o_pending       = 0;
            o_words_seen    = 0;
            o_overflow_runs = 0;
        end else begin
            if (i_sorted.valid && i_sorted.ready)
                check_word();
            if (i_rec.valid && i_rec.ready)
                take_record('{key: trim_key(i_rec.sort_key), label: i_rec.label_word,
                              weight: i_rec.weight_word}, i_rec.final_record);
            o_pending = sorted_due.size();
        end
    end

endmodule

[tb/record_sort_by_key_test.sv]
// record_sort_by_key_test: clock, reset and record stimulus for record_sort_by_key, plus verdict.
// Depends on rsbk_pkg, rsbk_in_if, rsbk_out_if, record_sort_by_key and record_sort_by_key_check.
module record_sort_by_key_test;

    localparam int ITEM_GOAL  = 230;
    localparam int QUIET_FROM = 190;  // no idling on either side from here on
    localparam int HOLD_FROM  = 80;   // long output hold starts near the end of the first full set
    localparam int LONG_HOLD  = 200;

    logic i_clk;
    logic i_rst_n;

    rsbk_in_if  in_ch ();
    rsbk_out_if out_ch ();

    int fail_count;
    int pending;
    int words_seen;
    int overflow_runs;
    int records_sent;
    int sets_sent;
    bit quiet_tail;

    record_sort_by_key dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    record_sort_by_key_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rec           (in_ch),
        .i_sorted        (out_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_seen    (words_seen),
        .o_overflow_runs (overflow_runs)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d sorted words still due", pending);
        $display("Test completed with failures");
        $finish;
    end

    // half full-range keys, the rest in clusters that collide or near the extremes
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 8) - 4;
            1: return {($urandom_range(0, 1) ? 16'h7FFF : 16'h8000), 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic offer_record(input logic [31:0] key, input logic [31:0] label,
                                input logic [31:0] weight, input logic fin, input bit gappy);
        in_ch.valid        <= 1'b1;
        in_ch.sort_key     <= key;
        in_ch.label_word   <= label;
        in_ch.weight_word  <= weight;
        in_ch.final_record <= fin;
        do @(posedge i_clk); while (!in_ch.ready);
        records_sent++;
        quiet_tail = (records_sent >= QUIET_FROM);
        if (fin)
            sets_sent++;
        if (gappy && !quiet_tail && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // receiver: random stall bursts, one long hold while the sender keeps going
    initial begin
        bit stall_mode;
        bit long_done;
        stall_mode = 1'b1;
        long_done  = 1'b0;
        out_ch.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0)
                stall_mode = !stall_mode;
            if (!long_done && records_sent >= HOLD_FROM) begin
                long_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (stall_mode && !quiet_tail && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [31:0] edge_keys [9];
        int          set_no;
        int          set_len;
        bit          gappy;
        edge_keys = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                      32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000,
                      32'h0000_0000};
        records_sent = 0;
        sets_sent    = 0;
        quiet_tail   = 1'b0;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.sort_key     <= '0;
        in_ch.label_word   <= '0;
        in_ch.weight_word  <= '0;
        in_ch.final_record <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // a set of one
        offer_record(32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1);
        // extreme keys, repeated extremes and the 16.16 values of plus and minus one
        for (int i = 0; i < 9; i++)
            offer_record(edge_keys[i], 32'hFFFF_FFFF ^ i, i, i == 8, 1'b1);
        // equal keys must leave in arrival order
        for (int i = 0; i < 5; i++)
            offer_record(32'h0003_8000, 32'h1000 + i, $urandom, i == 4, 1'b1);
        // strictly descending keys, every word moves on each insert
        for (int i = 0; i < 6; i++)
            offer_record(32'(5 - i) * 32'h0001_0000 - 32'h0002_0000, 32'h2000 + i,
                         $urandom, i == 5, 1'b1);

        set_no = 0;
        while (records_sent < ITEM_GOAL) begin
            case (set_no)
                0: set_len = rsbk_pkg::DEPTH;      // fills the store, nothing dropped
                2: set_len = rsbk_pkg::DEPTH + 1;  // final word arrives on a full store
                4: set_len = rsbk_pkg::DEPTH + 5;
                default: set_len = $urandom_range(1, 8);
            endcase
            gappy = ($urandom_range(0, 2) != 0);
            for (int r = 0; r < set_len; r++)
                offer_record(pick_key(), $urandom, $urandom, r == set_len - 1, gappy);
            set_no++;
        end
        in_ch.valid <= 1'b0;

        while (pending != 0)
            @(negedge i_clk);
        repeat (rsbk_pkg::DEPTH + 8) @(posedge i_clk);

        $display("Covered %0d records in %0d sets; %0d sorted words compared.",
                 records_sent, sets_sent, words_seen);
        $display("%0d sets overran the %0d-entry store; output held for %0d cycles once.",
                 overflow_runs, rsbk_pkg::DEPTH, LONG_HOLD);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
